### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define PRPP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Clocked check that also holds through reset.
`define PRPP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

### rtl/core/prpp_pkg.sv
// Types and constants of the point rotate / perspective project unit.
// No dependencies; used by the top level and its checker.
package prpp_pkg;

    localparam int ADDR_W   = 5;
    localparam int CENTER_W = 12;
    localparam logic [CENTER_W-1:0] CENTER_X_DEF = 12'd80;
    localparam logic [CENTER_W-1:0] CENTER_Y_DEF = 12'd50;

    // datapath widths
    localparam int CRD_W  = 17;  // point minus camera
    localparam int ROT_W  = 34;  // a, b
    localparam int SUM1_W = 51;  // second rotation sums, 28 fraction bits
    localparam int MID_W  = 36;  // dx, u
    localparam int SUM2_W = 54;  // third rotation sums
    localparam int DEP_W  = 38;  // dy, dz
    localparam int ABS_W  = 37;  // |dx|, |dy|, positive dz
    localparam int MAG_W  = 52;  // focal * |d|
    localparam int DEN_W  = 38;  // 2 * dz
    localparam int NUM_W  = 55;  // 2 * mag + dz, also holds den << QUO_W
    localparam int QUO_W  = 17;  // quotient bits; larger quotients saturate
    localparam int OUTS_W = 20;  // signed quotient plus center

    localparam logic signed [OUTS_W-1:0] SAT_MAX = 20'sd32767;
    localparam logic signed [OUTS_W-1:0] SAT_MIN = -20'sd32768;

    // register indexes
    localparam logic [2:0] REG_CAMERA_X     = 3'd0;
    localparam logic [2:0] REG_CAMERA_Y     = 3'd1;
    localparam logic [2:0] REG_CAMERA_Z     = 3'd2;
    localparam logic [2:0] REG_TRIG_ABOUT_X = 3'd3;
    localparam logic [2:0] REG_TRIG_ABOUT_Y = 3'd4;
    localparam logic [2:0] REG_TRIG_ABOUT_Z = 3'd5;
    localparam logic [2:0] REG_FOCAL        = 3'd6;

    // reset values
    localparam logic [15:0] CAMERA_X_RST = 16'h0000;
    localparam logic [15:0] CAMERA_Y_RST = 16'h0000;
    localparam logic [15:0] CAMERA_Z_RST = 16'hFFCE;
    localparam logic [31:0] TRIG_X_RST   = 32'h4000_0000;
    localparam logic [31:0] TRIG_Y_RST   = 32'h0000_4000;
    localparam logic [31:0] TRIG_Z_RST   = 32'h4000_0000;
    localparam logic [14:0] FOCAL_RST    = 15'd80;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
    } in_t;

    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic               behind_camera;
        logic               clipped;
    } out_t;

    // one step of the pipelined divider
    typedef struct packed {
        logic             behind;
        logic             neg_x;
        logic             neg_y;
        logic             ovf_x;
        logic             ovf_y;
        logic [NUM_W-1:0] rem_x;
        logic [NUM_W-1:0] rem_y;
        logic [QUO_W-1:0] quo_x;
        logic [QUO_W-1:0] quo_y;
        logic [DEN_W-1:0] den;
    } div_t;

endpackage

### rtl/core/point_rotate_perspective_project_unit.sv
// Point rotate and perspective project unit: top level.
// Depends on prpp_pkg.
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries one world point per item.
//   Result channel m_valid/m_ready/m_data carries screen_x, screen_y,
//   behind_camera and clipped for each point, in order.
//   Camera position, Q2.14 cosine/sine pairs and focal distance are written
//   over the APB port (register i at byte address 4*i); pready is tied high.
// Timing:
//   From accept to result valid an item passes the subtract, three
//   rotation stages, focal scale, divider setup, 17 divider stages (one
//   quotient bit each) and the output register.
//   One item per cycle unless stalled; the divider stages set the depth.
// Reset (synchronous, aresetn low): pipeline empties, registers return to
//   camera (0, 0, -50), angles 0/90/0 degrees, focal distance 80.
// Stall: while m_valid is high and m_ready low, the whole pipeline holds
//   and s_ready drops; nothing is lost or repeated.
module point_rotate_perspective_project_unit #(
    parameter logic [prpp_pkg::CENTER_W-1:0] CENTER_X = prpp_pkg::CENTER_X_DEF,
    parameter logic [prpp_pkg::CENTER_W-1:0] CENTER_Y = prpp_pkg::CENTER_Y_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prpp_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  prpp_pkg::in_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output prpp_pkg::out_t                m_data
);

    localparam int QW = prpp_pkg::QUO_W;

    // configuration
    logic [15:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic [31:0] trig_x_reg, trig_y_reg, trig_z_reg;
    logic [14:0] focal_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[prpp_pkg::ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg  <= prpp_pkg::CAMERA_X_RST;
            cam_y_reg  <= prpp_pkg::CAMERA_Y_RST;
            cam_z_reg  <= prpp_pkg::CAMERA_Z_RST;
            trig_x_reg <= prpp_pkg::TRIG_X_RST;
            trig_y_reg <= prpp_pkg::TRIG_Y_RST;
            trig_z_reg <= prpp_pkg::TRIG_Z_RST;
            focal_reg  <= prpp_pkg::FOCAL_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                prpp_pkg::REG_CAMERA_X:     cam_x_reg  <= pwdata[15:0];
                prpp_pkg::REG_CAMERA_Y:     cam_y_reg  <= pwdata[15:0];
                prpp_pkg::REG_CAMERA_Z:     cam_z_reg  <= pwdata[15:0];
                prpp_pkg::REG_TRIG_ABOUT_X: trig_x_reg <= pwdata;
                prpp_pkg::REG_TRIG_ABOUT_Y: trig_y_reg <= pwdata;
                prpp_pkg::REG_TRIG_ABOUT_Z: trig_z_reg <= pwdata;
                prpp_pkg::REG_FOCAL:        focal_reg  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            prpp_pkg::REG_CAMERA_X:     prdata = {16'd0, cam_x_reg};
            prpp_pkg::REG_CAMERA_Y:     prdata = {16'd0, cam_y_reg};
            prpp_pkg::REG_CAMERA_Z:     prdata = {16'd0, cam_z_reg};
            prpp_pkg::REG_TRIG_ABOUT_X: prdata = trig_x_reg;
            prpp_pkg::REG_TRIG_ABOUT_Y: prdata = trig_y_reg;
            prpp_pkg::REG_TRIG_ABOUT_Z: prdata = trig_z_reg;
            prpp_pkg::REG_FOCAL:        prdata = {17'd0, focal_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    logic signed [15:0] cx, sx, cy, sy, cz, sz;
    assign cx = trig_x_reg[31:16];
    assign sx = trig_x_reg[15:0];
    assign cy = trig_y_reg[31:16];
    assign sy = trig_y_reg[15:0];
    assign cz = trig_z_reg[31:16];
    assign sz = trig_z_reg[15:0];

    // pipeline advance: everything moves unless the output item is stalled
    logic en;
    logic m_valid_reg;
    prpp_pkg::out_t m_data_reg, m_data_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage 1: point minus camera
    logic                             s1_vld_reg;
    logic signed [prpp_pkg::CRD_W-1:0] s1_x_reg, s1_y_reg, s1_z_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_x_reg <= {s_data.point_x[15], s_data.point_x} - {cam_x_reg[15], cam_x_reg};
            s1_y_reg <= {s_data.point_y[15], s_data.point_y} - {cam_y_reg[15], cam_y_reg};
            s1_z_reg <= {s_data.point_z[15], s_data.point_z} - {cam_z_reg[15], cam_z_reg};
        end
    end

    // stage 2: rotation about z
    logic                              s2_vld_reg;
    logic signed [32:0]                p_zy, p_zx, p_cy, p_sx;
    logic signed [prpp_pkg::ROT_W-1:0] s2_a_reg, s2_b_reg;
    logic signed [prpp_pkg::CRD_W-1:0] s2_z_reg;

    assign p_zy = sz * s1_y_reg;
    assign p_zx = cz * s1_x_reg;
    assign p_cy = cz * s1_y_reg;
    assign p_sx = sz * s1_x_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_a_reg <= prpp_pkg::ROT_W'(p_zy) + prpp_pkg::ROT_W'(p_zx);
            s2_b_reg <= prpp_pkg::ROT_W'(p_cy) - prpp_pkg::ROT_W'(p_sx);
            s2_z_reg <= s1_z_reg;
        end
    end

    // stage 3: rotation about y, round to 14 fraction bits
    logic                               s3_vld_reg;
    logic signed [49:0]                 p_ya, p_sa;
    logic signed [32:0]                 p_yz, p_cz;
    logic signed [prpp_pkg::SUM1_W-1:0] t_dx, t_u;
    logic signed [prpp_pkg::MID_W-1:0]  s3_dx_reg, s3_u_reg;
    logic signed [prpp_pkg::ROT_W-1:0]  s3_b_reg;

    assign p_ya = cy * s2_a_reg;
    assign p_sa = sy * s2_a_reg;
    assign p_yz = sy * s2_z_reg;
    assign p_cz = cy * s2_z_reg;
    assign t_dx = prpp_pkg::SUM1_W'(p_ya) - (prpp_pkg::SUM1_W'(p_yz) <<< 14)
                + 51'sd8192;
    assign t_u  = (prpp_pkg::SUM1_W'(p_cz) <<< 14) + prpp_pkg::SUM1_W'(p_sa)
                + 51'sd8192;

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_dx_reg <= prpp_pkg::MID_W'(t_dx >>> 14);
            s3_u_reg  <= prpp_pkg::MID_W'(t_u >>> 14);
            s3_b_reg  <= s2_b_reg;
        end
    end

    // stage 4: rotation about x
    logic                               s4_vld_reg;
    logic signed [51:0]                 p_xu, p_cu;
    logic signed [49:0]                 p_cb, p_xb;
    logic signed [prpp_pkg::SUM2_W-1:0] t_dy, t_dz;
    logic signed [prpp_pkg::DEP_W-1:0]  s4_dx_reg, s4_dy_reg, s4_dz_reg;

    assign p_xu = sx * s3_u_reg;
    assign p_cu = cx * s3_u_reg;
    assign p_cb = cx * s3_b_reg;
    assign p_xb = sx * s3_b_reg;
    assign t_dy = prpp_pkg::SUM2_W'(p_xu) + prpp_pkg::SUM2_W'(p_cb) + 54'sd8192;
    assign t_dz = prpp_pkg::SUM2_W'(p_cu) - prpp_pkg::SUM2_W'(p_xb) + 54'sd8192;

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_dx_reg <= prpp_pkg::DEP_W'(s3_dx_reg);
            s4_dy_reg <= prpp_pkg::DEP_W'(t_dy >>> 14);
            s4_dz_reg <= prpp_pkg::DEP_W'(t_dz >>> 14);
        end
    end

    // stage 5: depth test, magnitudes scaled by focal distance
    logic                              s5_vld_reg;
    logic [prpp_pkg::ABS_W-1:0]        abs_x, abs_y;
    logic signed [prpp_pkg::DEP_W-1:0] neg_dx, neg_dy;
    logic                              s5_behind_reg, s5_nx_reg, s5_ny_reg;
    logic [prpp_pkg::MAG_W-1:0]        s5_mx_reg, s5_my_reg;
    logic [prpp_pkg::ABS_W-1:0]        s5_dz_reg;

    assign neg_dx = -s4_dx_reg;
    assign neg_dy = -s4_dy_reg;
    assign abs_x  = s4_dx_reg[prpp_pkg::DEP_W-1] ? neg_dx[prpp_pkg::ABS_W-1:0]
                                                  : s4_dx_reg[prpp_pkg::ABS_W-1:0];
    assign abs_y  = s4_dy_reg[prpp_pkg::DEP_W-1] ? neg_dy[prpp_pkg::ABS_W-1:0]
                                                  : s4_dy_reg[prpp_pkg::ABS_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_behind_reg <= s4_dz_reg[prpp_pkg::DEP_W-1] || (s4_dz_reg == '0);
            s5_nx_reg     <= s4_dx_reg[prpp_pkg::DEP_W-1];
            s5_ny_reg     <= s4_dy_reg[prpp_pkg::DEP_W-1];
            s5_mx_reg     <= prpp_pkg::MAG_W'(focal_reg) * prpp_pkg::MAG_W'(abs_x);
            s5_my_reg     <= prpp_pkg::MAG_W'(focal_reg) * prpp_pkg::MAG_W'(abs_y);
            s5_dz_reg     <= s4_dz_reg[prpp_pkg::ABS_W-1:0];
        end
    end

    // divider: q = (2*mag + dz) / (2*dz), one quotient bit per stage.
    // Quotients of 2^QW or more saturate the screen position anyway.
    prpp_pkg::div_t div_reg  [QW+1];
    prpp_pkg::div_t div_next [QW+1];
    logic [QW:0]    dvld_reg;

    always_comb begin
        logic [prpp_pkg::DEN_W-1:0] den;
        logic [prpp_pkg::NUM_W-1:0] num_x, num_y, lim;
        logic [prpp_pkg::NUM_W-1:0] trial;
        den   = {s5_dz_reg, 1'b0};
        num_x = prpp_pkg::NUM_W'({s5_mx_reg, 1'b0}) + prpp_pkg::NUM_W'(s5_dz_reg);
        num_y = prpp_pkg::NUM_W'({s5_my_reg, 1'b0}) + prpp_pkg::NUM_W'(s5_dz_reg);
        lim   = prpp_pkg::NUM_W'(den) << QW;
        div_next[0].behind = s5_behind_reg;
        div_next[0].neg_x  = s5_nx_reg;
        div_next[0].neg_y  = s5_ny_reg;
        div_next[0].ovf_x  = num_x >= lim;
        div_next[0].ovf_y  = num_y >= lim;
        div_next[0].rem_x  = num_x;
        div_next[0].rem_y  = num_y;
        div_next[0].quo_x  = '0;
        div_next[0].quo_y  = '0;
        div_next[0].den    = den;
        for (int i = 0; i < QW; i++) begin
            trial = prpp_pkg::NUM_W'(div_reg[i].den) << (QW - 1 - i);
            div_next[i+1] = div_reg[i];
            if (div_reg[i].rem_x >= trial) begin
                div_next[i+1].rem_x = div_reg[i].rem_x - trial;
                div_next[i+1].quo_x[QW-1-i] = 1'b1;
            end
            if (div_reg[i].rem_y >= trial) begin
                div_next[i+1].rem_y = div_reg[i].rem_y - trial;
                div_next[i+1].quo_y[QW-1-i] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i <= QW; i++) begin
                div_reg[i] <= div_next[i];
            end
        end
    end

    // output: sign, center offset, saturation
    logic [QW:0]                        qm_x, qm_y;
    logic signed [prpp_pkg::OUTS_W-1:0] vx, vy, ox, oy;
    logic                               clip_x, clip_y;

    assign qm_x = div_reg[QW].ovf_x ? {1'b1, QW'(0)} : {1'b0, div_reg[QW].quo_x};
    assign qm_y = div_reg[QW].ovf_y ? {1'b1, QW'(0)} : {1'b0, div_reg[QW].quo_y};

    always_comb begin
        vx = $signed(prpp_pkg::OUTS_W'(qm_x));
        vy = $signed(prpp_pkg::OUTS_W'(qm_y));
        if (div_reg[QW].neg_x) begin
            vx = -vx;
        end
        if (div_reg[QW].neg_y) begin
            vy = -vy;
        end
        vx = vx + $signed(prpp_pkg::OUTS_W'(CENTER_X));
        vy = vy + $signed(prpp_pkg::OUTS_W'(CENTER_Y));
        clip_x = (vx > prpp_pkg::SAT_MAX) || (vx < prpp_pkg::SAT_MIN);
        clip_y = (vy > prpp_pkg::SAT_MAX) || (vy < prpp_pkg::SAT_MIN);
        ox = vx;
        oy = vy;
        if (vx > prpp_pkg::SAT_MAX) begin
            ox = prpp_pkg::SAT_MAX;
        end else if (vx < prpp_pkg::SAT_MIN) begin
            ox = prpp_pkg::SAT_MIN;
        end
        if (vy > prpp_pkg::SAT_MAX) begin
            oy = prpp_pkg::SAT_MAX;
        end else if (vy < prpp_pkg::SAT_MIN) begin
            oy = prpp_pkg::SAT_MIN;
        end
        if (div_reg[QW].behind) begin
            m_data_next.screen_x      = '0;
            m_data_next.screen_y      = '0;
            m_data_next.behind_camera = 1'b1;
            m_data_next.clipped       = 1'b0;
        end else begin
            m_data_next.screen_x      = ox[15:0];
            m_data_next.screen_y      = oy[15:0];
            m_data_next.behind_camera = 1'b0;
            m_data_next.clipped       = clip_x || clip_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            dvld_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg  <= s_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            dvld_reg    <= {dvld_reg[QW-1:0], s5_vld_reg};
            m_valid_reg <= dvld_reg[QW];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/core/prpp_checker.sv
// Port-level checks of the point rotate / perspective project unit.
// Depends on prpp_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module prpp_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input prpp_pkg::out_t m_data
);

    // result channel is empty in the cycle after reset is sampled
    `PRPP_ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_valid)

    // a stalled item holds
    `PRPP_ASSERT(a_stall_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))

    // points behind the camera give a zero position and no clip
    `PRPP_ASSERT(a_behind_zero, aclk, aresetn, m_valid && m_data.behind_camera |-> m_data.screen_x == 16'sd0 && m_data.screen_y == 16'sd0 && !m_data.clipped)

    // a clipped item shows a coordinate at a rail
    `PRPP_ASSERT(a_clip_rail, aclk, aresetn, m_valid && m_data.clipped |-> m_data.screen_x == 16'h7FFF || m_data.screen_x == 16'h8000 || m_data.screen_y == 16'h7FFF || m_data.screen_y == 16'h8000)

endmodule

bind point_rotate_perspective_project_unit prpp_checker u_prpp_checker (.*);

### tb/tb_top.sv
// Self-checking bench for the point rotate / perspective project unit.
// Depends on prpp_pkg and point_rotate_perspective_project_unit; drives APB
// register writes, a directed table and random points, checks every result.
`timescale 1ns / 1ps

module tb_top;

    localparam int  CX_SCR = 80;
    localparam int  CY_SCR = 50;
    localparam int  N_RAND = 1250;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int  PIPE_DRAIN = 40;
    // index with no register behind it
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [prpp_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    prpp_pkg::in_t  s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    prpp_pkg::out_t m_data;

    point_rotate_perspective_project_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #6 aclk = ~aclk;

    // shadow copy of the camera setup
    logic [15:0] cam_x, cam_y, cam_z;
    logic [31:0] rot_x, rot_y, rot_z;
    logic [14:0] focal;

    prpp_pkg::out_t screen_q[$];
    int     n_err = 0;
    int     n_seen = 0;
    int     n_behind = 0;
    int     n_clip = 0;
    int     rx_hold = 0;
    longint cyc = 0;
    bit     rx_idle_on = 1'b1;

    function automatic longint rnd14(longint v);
        longint t;
        t = v + 8192;
        return t >>> 14;  // arithmetic shift is a floor
    endfunction

    function automatic longint div_near(longint num, longint den);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic prpp_pkg::out_t project_point(prpp_pkg::in_t p);
        longint dx_w, dy_w, dz_w, a, b, dx, u, dy, dz, sx_w, sy_w;
        longint c_x, s_x, c_y, s_y, c_z, s_z;
        prpp_pkg::out_t r;
        dx_w = longint'(p.point_x) - longint'($signed(cam_x));
        dy_w = longint'(p.point_y) - longint'($signed(cam_y));
        dz_w = longint'(p.point_z) - longint'($signed(cam_z));
        c_x = $signed(rot_x[31:16]); s_x = $signed(rot_x[15:0]);
        c_y = $signed(rot_y[31:16]); s_y = $signed(rot_y[15:0]);
        c_z = $signed(rot_z[31:16]); s_z = $signed(rot_z[15:0]);
        a  = s_z * dy_w + c_z * dx_w;
        b  = c_z * dy_w - s_z * dx_w;
        dx = rnd14(c_y * a - s_y * dz_w * 16384);
        u  = rnd14(c_y * dz_w * 16384 + s_y * a);
        dy = rnd14(s_x * u + c_x * b);
        dz = rnd14(c_x * u - s_x * b);
        r = '0;
        if (dz <= 0) begin
            r.behind_camera = 1'b1;
            return r;
        end
        sx_w = div_near(longint'(focal) * dx, dz) + CX_SCR;
        sy_w = div_near(longint'(focal) * dy, dz) + CY_SCR;
        if (sx_w > 32767) begin sx_w = 32767; r.clipped = 1'b1; end
        if (sx_w < -32768) begin sx_w = -32768; r.clipped = 1'b1; end
        if (sy_w > 32767) begin sy_w = 32767; r.clipped = 1'b1; end
        if (sy_w < -32768) begin sy_w = -32768; r.clipped = 1'b1; end
        r.screen_x = sx_w[15:0];
        r.screen_y = sy_w[15:0];
        return r;
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= prpp_pkg::ADDR_W'({idx, 2'b00}); pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            prpp_pkg::REG_CAMERA_X:     cam_x = val[15:0];
            prpp_pkg::REG_CAMERA_Y:     cam_y = val[15:0];
            prpp_pkg::REG_CAMERA_Z:     cam_z = val[15:0];
            prpp_pkg::REG_TRIG_ABOUT_X: rot_x = val;
            prpp_pkg::REG_TRIG_ABOUT_Y: rot_y = val;
            prpp_pkg::REG_TRIG_ABOUT_Z: rot_z = val;
            prpp_pkg::REG_FOCAL:        focal = val[14:0];
            default: ;
        endcase
    endtask

    task automatic set_camera(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z, input logic [31:0] tx,
                              input logic [31:0] ty, input logic [31:0] tz,
                              input logic [14:0] f);
        reg_write(prpp_pkg::REG_CAMERA_X, {16'h0, x});
        reg_write(prpp_pkg::REG_CAMERA_Y, {16'h0, y});
        reg_write(prpp_pkg::REG_CAMERA_Z, {16'h0, z});
        reg_write(prpp_pkg::REG_TRIG_ABOUT_X, tx);
        reg_write(prpp_pkg::REG_TRIG_ABOUT_Y, ty);
        reg_write(prpp_pkg::REG_TRIG_ABOUT_Z, tz);
        reg_write(prpp_pkg::REG_FOCAL, {17'h0, f});
    endtask

    // drive one point; optional idle burst first; valid stays up between
    // back-to-back items and is dropped only for idles and drains
    task automatic send_point(input prpp_pkg::in_t p, input bit gaps,
                              input bit fixed = 1'b0,
                              input prpp_pkg::out_t want = '0);
        int n;
        if (gaps && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        screen_q.push_back(fixed ? want : project_point(p));
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (screen_q.size() != 0) @(negedge aclk);
        repeat (PIPE_DRAIN) @(negedge aclk);
    endtask

    function automatic logic [15:0] rnd_coord();
        case ($urandom_range(0, 3))
            0:       return 16'($signed($urandom_range(0, 400)) - 200);
            1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rnd_angle();
        real ang;
        int c, s;
        ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
        c = $rtoi($cos(ang) * 16384.0);
        s = $rtoi($sin(ang) * 16384.0);
        if ($urandom_range(0, 7) == 0) return $urandom;
        return {16'(c), 16'(s)};
    endfunction

    // result side: random stall bursts while rx_idle_on is set
    always @(negedge aclk) begin
        if (!rx_idle_on) begin
            m_ready <= 1'b1;
            rx_hold <= 0;
        end else if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            rx_hold <= $urandom_range(0, 8);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // check against oldest expectation
    always @(posedge aclk) begin
        prpp_pkg::out_t want;
        cyc <= cyc + 1;
        if (aresetn && m_valid && m_ready) begin
            if (screen_q.size() == 0) begin
                $error("result item with nothing expected: %h", m_data);
                n_err++;
            end else begin
                want = screen_q.pop_front();
                n_seen++;
                if (want.behind_camera) n_behind++;
                if (want.clipped) n_clip++;
                if (m_data.screen_x !== want.screen_x) begin
                    $error("screen_x exp %0d got %0d", want.screen_x, m_data.screen_x);
                    n_err++;
                end
                if (m_data.screen_y !== want.screen_y) begin
                    $error("screen_y exp %0d got %0d", want.screen_y, m_data.screen_y);
                    n_err++;
                end
                if (m_data.behind_camera !== want.behind_camera) begin
                    $error("behind_camera exp %0b got %0b",
                           want.behind_camera, m_data.behind_camera);
                    n_err++;
                end
                if (m_data.clipped !== want.clipped) begin
                    $error("clipped exp %0b got %0b", want.clipped, m_data.clipped);
                    n_err++;
                end
            end
        end
        if (cyc > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    typedef struct {
        prpp_pkg::in_t  pt;
        bit             fixed;
        prpp_pkg::out_t res;
    } dir_row_t;

    dir_row_t dir_tab[] = '{
        // reset camera at z=-50 looking +90 about y: point at origin
        '{'{16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        // point at the camera itself: depth zero
        '{'{16'sd0, 16'sd0, -16'sd50}, 1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b0}},
        '{'{16'sd100, 16'sd0, -16'sd50}, 1'b0, '0},
        '{'{-16'sd100, 16'sd20, -16'sd50}, 1'b0, '0},
        '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b0, '0},
        '{'{16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0},
        '{'{16'sh7FFF, 16'sh8000, 16'sd0}, 1'b0, '0},
        '{'{16'sh8000, 16'sh7FFF, -16'sd49}, 1'b0, '0},
        '{'{16'sd1, 16'sd30000, -16'sd50}, 1'b0, '0},
        '{'{16'sd5, -16'sd5, 16'sd3}, 1'b0, '0},
        '{'{-16'sd1, -16'sd1, -16'sd1}, 1'b0, '0},
        '{'{16'sd1, 16'sd1, 16'sd1}, 1'b0, '0}
    };

    initial begin
        prpp_pkg::in_t p;
        int  n_ph;
        cam_x = prpp_pkg::CAMERA_X_RST;
        cam_y = prpp_pkg::CAMERA_Y_RST;
        cam_z = prpp_pkg::CAMERA_Z_RST;
        rot_x = prpp_pkg::TRIG_X_RST;
        rot_y = prpp_pkg::TRIG_Y_RST;
        rot_z = prpp_pkg::TRIG_Z_RST;
        focal = prpp_pkg::FOCAL_RST;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_tab[i]) begin
            send_point(dir_tab[i].pt, 1'b1, dir_tab[i].fixed, dir_tab[i].res);
        end
        wait_drain();

        // straight-ahead camera, extreme focal lengths and positions
        set_camera(16'h0, 16'h0, 16'hFF9C, 32'h4000_0000, 32'h4000_0000,
                   32'h4000_0000, 15'd1);
        send_point('{16'sd10, 16'sd10, 16'sd0}, 1'b0);
        send_point('{16'sh7FFF, 16'sh8000, 16'sd1}, 1'b0);
        wait_drain();
        set_camera(16'h8000, 16'h7FFF, 16'h8000, 32'hC000_0000, 32'h0000_C000,
                   32'h0000_4000, 15'h7FFF);
        send_point('{16'sd0, 16'sd0, 16'sd0}, 1'b0);
        send_point('{16'sh7FFF, 16'sh8000, 16'sh7FFF}, 1'b0);
        send_point('{16'sh8000, 16'sh7FFF, 16'sh8000}, 1'b0);
        wait_drain();
        // zero focal; with this camera the point lands behind the camera
        reg_write(prpp_pkg::REG_FOCAL, 32'h0);
        send_point('{16'sd7, 16'sd9, 16'sd300}, 1'b0);
        wait_drain();
        // out-of-range register index is ignored
        reg_write(REG_UNUSED, 32'hFFFF_FFFF);

        for (int ph = 0; ph < 6; ph++) begin
            set_camera(16'($signed($urandom_range(0, 200)) - 100),
                       16'($signed($urandom_range(0, 200)) - 100),
                       ph == 5 ? 16'h8000 : 16'($signed($urandom_range(0, 400)) - 400),
                       rnd_angle(), rnd_angle(), rnd_angle(),
                       ph == 0 ? 15'h7FFF : 15'($urandom_range(1, 2000)));
            rx_idle_on = (ph != 5);
            n_ph = N_RAND / 6;
            for (int k = 0; k < n_ph; k++) begin
                p.point_x = rnd_coord();
                p.point_y = rnd_coord();
                p.point_z = rnd_coord();
                send_point(p, ph != 5);
            end
            wait_drain();
        end

        $display("checked %0d results: %0d behind the camera, %0d clipped",
                 n_seen, n_behind, n_clip);
        if (n_err == 0) $display("tb_top: done, clean");
        else $display("tb_top: done, errors");
        $finish;
    end
endmodule

### files.f
+incdir+rtl/core
rtl/core/prpp_pkg.sv
rtl/core/point_rotate_perspective_project_unit.sv
rtl/core/prpp_checker.sv
tb/tb_top.sv
